// ===== rtl/core/bmi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmi_pkg: shared types and constants for the bilinear map interpolator
// Field widths, item kinds, configuration indexes and front/back queue entry.
// ----------------------------------------------------------------------------
package bmi_pkg;
   localparam int PosPoints   = 12;
   localparam int SpdPoints   = 12;
   localparam int PosIdxW     = $clog2(PosPoints);
   localparam int SpdIdxW     = $clog2(SpdPoints);
   localparam int MapDepth    = PosPoints * SpdPoints;
   localparam int MapAddrW    = $clog2(MapDepth);
   localparam int FullScale   = 255;

   localparam logic [1:0] KIND_LOOKUP  = 2'd0;
   localparam logic [1:0] KIND_MAP     = 2'd1;
   localparam logic [1:0] KIND_POS_PT  = 2'd2;
   localparam logic [1:0] KIND_SPD_PT  = 2'd3;

   localparam logic [0:0] CSR_CLOSED = 1'b0;
   localparam logic [0:0] CSR_OPEN   = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  pedal;
      logic [15:0] speed;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [15:0] value;
   } item_type;
endpackage

// ===== rtl/core/bmi_front.sv =====
// ----------------------------------------------------------------------------
// bmi_front: input stage and item queue
// Accept beats, drop out-of-range writes, and hold up to four items for the
// back end.
// ----------------------------------------------------------------------------
module bmi_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bmi_pkg::item_type  req_item,
   output logic               q_valid,
   input  logic               q_pop,
   output bmi_pkg::item_type  q_item
);
   bmi_pkg::item_type mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       push, keep;

   always_comb begin
      keep = 1'b1;
      unique case (req_item.kind)
         bmi_pkg::KIND_MAP: keep = (req_item.row < 4'(bmi_pkg::SpdPoints)) &&
                                   (req_item.col < 4'(bmi_pkg::PosPoints));
         bmi_pkg::KIND_POS_PT: keep = req_item.row < 4'(bmi_pkg::PosPoints);
         bmi_pkg::KIND_SPD_PT: keep = req_item.row < 4'(bmi_pkg::SpdPoints);
         default: keep = 1'b1;
      endcase
   end

   assign req_tready = cnt_ff != 3'd4;
   assign push = req_tvalid && req_tready && keep;
   assign q_valid = cnt_ff != 3'd0;
   assign q_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= req_item;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (q_pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(q_pop);
      end
   end
endmodule

// ===== rtl/core/bmi_back.sv =====
// ----------------------------------------------------------------------------
// bmi_back: table storage and lookup sequencer
// Store writes; for a lookup scale the pedal, search segments, gather four
// cells, blend, and divide bit-serially.
// ----------------------------------------------------------------------------
module bmi_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  bmi_pkg::item_type q_item,
   input  logic [9:0]        closed,
   input  logic [9:0]        open_rd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_level,
   output logic              rsp_clamp
);
   localparam int SpdIdxW = bmi_pkg::SpdIdxW;
   localparam logic [3:0] S_IDLE = 4'd0, S_SCL = 4'd1, S_SDIV = 4'd2, S_SRCH = 4'd3,
      S_WGT = 4'd4, S_RD = 4'd5, S_MUL = 4'd6, S_ACC = 4'd7, S_DEN = 4'd8,
      S_DIV = 4'd9, S_OUT = 4'd10;

   logic [7:0]  map_mem [bmi_pkg::MapDepth];
   logic [7:0]  pos_ff [bmi_pkg::PosPoints];
   logic [15:0] spd_ff [bmi_pkg::SpdPoints];

   logic [3:0]  st_ff, st_in;
   logic [15:0] speed_ff;
   logic [9:0]  pedal_ff;
   logic        clamp_ff;
   logic        clamp_out_ff;
   logic [17:0] num_ff;
   logic [9:0]  dsp_ff;
   logic [8:0]  pos_ff2;
   logic [4:0]  ri_ff, pi_ff;
   logic        rdone_ff, pdone_ff;
   logic [15:0] wr1_ff, wr2_ff, dr_ff;
   logic [7:0]  wp1_ff, wp2_ff, dp_ff;
   logic [1:0]  k_ff;
   logic [7:0]  cell_ff;
   logic [23:0] pw_ff;
   logic [39:0] acc_ff, rem_ff, quo_ff;
   logic [23:0] den_ff;
   logic [5:0]  bit_ff;
   logic [7:0]  lvl_ff;
   logic        ovalid_ff;
   logic [bmi_pkg::MapAddrW-1:0] addr;
   logic [bmi_pkg::MapAddrW-1:0] waddr;
   logic [SpdIdxW:0] r1;
   logic [bmi_pkg::PosIdxW:0] p1;
   logic [40:0] trial;
   logic [15:0] sv, slo, shi;
   logic [7:0]  plo, phi, pv;

   assign q_pop = q_valid && st_ff == S_IDLE;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_level = lvl_ff;
   assign rsp_clamp = clamp_out_ff;

   assign waddr = bmi_pkg::MapAddrW'(q_item.row) * bmi_pkg::MapAddrW'(bmi_pkg::PosPoints)
                  + bmi_pkg::MapAddrW'(q_item.col);

   assign r1 = ri_ff[SpdIdxW:0];
   assign p1 = pi_ff[bmi_pkg::PosIdxW:0];
   always_comb begin
      unique case (k_ff)
         2'd0: addr = bmi_pkg::MapAddrW'((r1 - 1'b1) * bmi_pkg::PosPoints + (p1 - 1'b1));
         2'd1: addr = bmi_pkg::MapAddrW'((r1 - 1'b1) * bmi_pkg::PosPoints + p1);
         2'd2: addr = bmi_pkg::MapAddrW'(r1 * bmi_pkg::PosPoints + (p1 - 1'b1));
         default: addr = bmi_pkg::MapAddrW'(r1 * bmi_pkg::PosPoints + p1);
      endcase
      trial = {rem_ff, acc_ff[39]} - {17'd0, den_ff};
      slo = spd_ff[SpdIdxW'(ri_ff - 5'd1)];
      shi = spd_ff[SpdIdxW'(ri_ff)];
      plo = pos_ff[bmi_pkg::PosIdxW'(pi_ff - 5'd1)];
      phi = pos_ff[bmi_pkg::PosIdxW'(pi_ff)];
      sv = speed_ff;
      pv = pos_ff2[7:0];
      if (sv < slo) sv = slo;
      if (sv > shi) sv = shi;
      if (pv < plo) pv = plo;
      if (pv > phi) pv = phi;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (q_valid && q_item.kind == bmi_pkg::KIND_LOOKUP) st_in = S_SCL;
         S_SCL:  st_in = (pedal_ff <= closed || open_rd <= closed) ? S_SRCH : S_SDIV;
         S_SDIV: if (bit_ff == 6'd17) st_in = S_SRCH;
         S_SRCH: if (rdone_ff && pdone_ff) st_in = S_WGT;
         S_WGT:  st_in = S_RD;
         S_RD:   st_in = S_MUL;
         S_MUL:  st_in = S_ACC;
         S_ACC:  st_in = (k_ff == 2'd3) ? S_DEN : S_RD;
         S_DEN:  st_in = S_DIV;
         S_DIV:  if (bit_ff == 6'd39) st_in = S_OUT;
         S_OUT:  if (!ovalid_ff || rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         unique case (q_item.kind)
            bmi_pkg::KIND_MAP: map_mem[waddr] <= q_item.value[7:0];
            bmi_pkg::KIND_POS_PT: pos_ff[bmi_pkg::PosIdxW'(q_item.row)] <= q_item.value[7:0];
            bmi_pkg::KIND_SPD_PT: spd_ff[SpdIdxW'(q_item.row)] <= q_item.value;
            default: ;
         endcase
      end
      if (st_ff == S_RD) cell_ff <= map_mem[addr];
      unique case (st_ff)
         S_IDLE: begin
            speed_ff <= q_item.speed; pedal_ff <= q_item.pedal; clamp_ff <= 1'b0;
            ri_ff <= 5'd1; pi_ff <= 5'd1; rdone_ff <= 1'b0; pdone_ff <= 1'b0;
         end
         S_SCL: begin
            if (pedal_ff <= closed) pos_ff2 <= 9'd0;
            else if (open_rd <= closed) pos_ff2 <= 9'd255;
            num_ff <= 18'(pedal_ff - closed) * 18'd255;
            dsp_ff <= open_rd - closed;
            rem_ff <= '0; bit_ff <= '0; quo_ff <= '0;
            if (speed_ff < spd_ff[0]) begin
               if (spd_ff[0] > spd_ff[bmi_pkg::SpdPoints-1])
                  speed_ff <= spd_ff[bmi_pkg::SpdPoints-1];
               else speed_ff <= spd_ff[0];
               clamp_ff <= 1'b1;
            end else if (speed_ff > spd_ff[bmi_pkg::SpdPoints-1]) begin
               speed_ff <= spd_ff[bmi_pkg::SpdPoints-1]; clamp_ff <= 1'b1;
            end
         end
         S_SDIV: begin
            if ({rem_ff[9:0], num_ff[17]} >= {1'b0, dsp_ff}) begin
               rem_ff[10:0] <= {rem_ff[9:0], num_ff[17]} - {1'b0, dsp_ff};
               quo_ff[17:0] <= {quo_ff[16:0], 1'b1};
            end else begin
               rem_ff[10:0] <= {rem_ff[9:0], num_ff[17]};
               quo_ff[17:0] <= {quo_ff[16:0], 1'b0};
            end
            num_ff <= {num_ff[16:0], 1'b0};
            bit_ff <= bit_ff + 6'd1;
            if (bit_ff == 6'd17) pos_ff2 <= 9'(({quo_ff[16:0], ({rem_ff[9:0], num_ff[17]}
               >= {1'b0, dsp_ff})} > 18'd255) ? 18'd255 :
               {quo_ff[16:0], ({rem_ff[9:0], num_ff[17]} >= {1'b0, dsp_ff})});
         end
         S_SRCH: begin
            if (!rdone_ff) begin
               if (speed_ff <= spd_ff[SpdIdxW'(ri_ff)] || ri_ff == 5'(bmi_pkg::SpdPoints-1))
                  rdone_ff <= 1'b1;
               else ri_ff <= ri_ff + 5'd1;
            end
            if (!pdone_ff) begin
               if (pos_ff2 < {1'b0, pos_ff[bmi_pkg::PosIdxW'(pi_ff)]} ||
                   pi_ff == 5'(bmi_pkg::PosPoints-1)) pdone_ff <= 1'b1;
               else pi_ff <= pi_ff + 5'd1;
            end
         end
         S_WGT: begin
            if (shi <= slo) begin wr1_ff <= 16'd1; wr2_ff <= 16'd0; dr_ff <= 16'd1; end
            else begin wr1_ff <= shi - sv; wr2_ff <= sv - slo; dr_ff <= shi - slo; end
            if (phi <= plo) begin wp1_ff <= 8'd1; wp2_ff <= 8'd0; dp_ff <= 8'd1; end
            else begin wp1_ff <= phi - pv; wp2_ff <= pv - plo; dp_ff <= phi - plo; end
            k_ff <= 2'd0; acc_ff <= '0;
         end
         S_MUL: pw_ff <= (k_ff[0] ? wp2_ff : wp1_ff) * (k_ff[1] ? wr2_ff : wr1_ff);
         S_ACC: begin
            acc_ff <= acc_ff + 40'(cell_ff) * 40'(pw_ff);
            k_ff <= k_ff + 2'd1;
         end
         S_DEN: begin
            den_ff <= dp_ff * dr_ff; rem_ff <= '0; bit_ff <= '0; quo_ff <= '0;
         end
         S_DIV: begin
            if (!trial[40]) begin
               rem_ff <= trial[39:0]; quo_ff <= {quo_ff[38:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[38:0], acc_ff[39]}; quo_ff <= {quo_ff[38:0], 1'b0};
            end
            acc_ff <= {acc_ff[38:0], 1'b0};
            bit_ff <= bit_ff + 6'd1;
         end
         default: ;
      endcase
      if (st_ff == S_OUT && (!ovalid_ff || rsp_tready)) begin
         lvl_ff <= (quo_ff > 40'd255) ? 8'd255 : quo_ff[7:0];
         clamp_out_ff <= clamp_ff;
      end
      if (reset) begin
         st_ff <= S_IDLE; ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_OUT && (!ovalid_ff || rsp_tready)) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
      end
   end
endmodule

// ===== rtl/core/bilinear_map_interpolator.sv =====
// ----------------------------------------------------------------------------
// bilinear_map_interpolator: 12x12 byte map with bilinear lookup
// A lookup passes, from leaving the queue to its result beat, through an 18-step
// pedal scaling divider (skipped when the pedal is at or below the closed reading
// or the calibration span is empty), a breakpoint search, four serial cell reads
// through the single map port, and a 40-step restoring divider for the final
// blend; it then waits in its output step while an earlier result beat is stalled.
// One lookup runs at a time; write items are stored as they leave the queue.
// A four-entry queue decouples the input.
// ----------------------------------------------------------------------------
module bilinear_map_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pedal_reading, engine_speed, row_index, col_index,
                                    // write_value, zero pad
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // drive_level
   output logic        rsp_tuser,   // speed_clamped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);
   bmi_pkg::item_type item, q_item;
   logic q_valid, q_pop;
   logic [9:0] closed_ff, open_ff;

   assign item = '{kind: req_tuser, pedal: req_tdata[9:0], speed: req_tdata[25:10],
                   row: req_tdata[29:26], col: req_tdata[33:30], value: req_tdata[49:34]};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 10'd205; open_ff <= 10'd819;
      end else if (csr_valid) begin
         unique case (csr_index)
            bmi_pkg::CSR_CLOSED: closed_ff <= csr_data;
            default: open_ff <= csr_data;
         endcase
      end
   end

   bmi_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_item(item),
      .q_valid, .q_pop, .q_item);

   bmi_back u_back (.clock, .reset, .q_valid, .q_pop, .q_item, .closed(closed_ff),
      .open_rd(open_ff), .rsp_tvalid, .rsp_tready, .rsp_level(rsp_tdata),
      .rsp_clamp(rsp_tuser));
endmodule

// ===== rtl/core/bmi_checker.sv =====
// ----------------------------------------------------------------------------
// bmi_checker: port-level checks
// Result beats hold while stalled; no result right after reset; csr always ready.
// ----------------------------------------------------------------------------
module bmi_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("hold");
   a_hold_user: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tuser)) else $error("hold user");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rst");
   a_csr: assert property (@(posedge clock) !reset |-> csr_ready) else $error("csr");
endmodule

bind bilinear_map_interpolator bmi_checker u_chk (.clock, .reset, .rsp_tvalid,
   .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_ready);
